// ----- design/dg3_pkg.sv -----
// shared constants and types for the diagonal 3x3 convolution block
`default_nettype none

package dg3_pkg;

    localparam int MAX_DIM_DEF     = 32;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int DIM_RESET       = 32;
    localparam int DIM_MIN_BITS    = 6;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;
    localparam int Q_DEPTH         = 4;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef struct packed {
        logic first;
        logic second;
    } push_ctl_t;

endpackage

`default_nettype wire

// ----- design/dg3_cell.sv -----
// one column cell of the line store: a sample of the row above and of the row two above
`default_nettype none

module dg3_cell #(
    parameter int W = dg3_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         shift_en,
    input  wire logic         inject,
    input  wire logic [W-1:0] new_prev,
    input  wire logic [W-1:0] new_older,
    input  wire logic [W-1:0] nb_prev,
    input  wire logic [W-1:0] nb_older,
    output logic      [W-1:0] prev_q,
    output logic      [W-1:0] older_q
);

    logic [W-1:0] prev_reg;
    logic [W-1:0] older_reg;
    logic [W-1:0] prev_next;
    logic [W-1:0] older_next;

    always_comb begin
        prev_next  = inject ? new_prev  : nb_prev;
        older_next = inject ? new_older : nb_older;
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            prev_reg  <= prev_next;
            older_reg <= older_next;
        end
    end

    assign prev_q  = prev_reg;
    assign older_q = older_reg;

endmodule

`default_nettype wire

// ----- design/dg3_line_chain.sv -----
// chain of line store cells; samples enter at the last column's cell and leave at cell zero
`default_nettype none

module dg3_line_chain #(
    parameter int MAX_DIM = dg3_pkg::MAX_DIM_DEF,
    parameter int W       = dg3_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       shift_en,
    input  wire logic [$clog2(MAX_DIM)-1:0] inj_pos,
    input  wire logic [W-1:0]               new_sample,
    output logic      [W-1:0]               up,
    output logic      [W-1:0]               upup
);

    localparam int IDX_W = $clog2(MAX_DIM);

    logic [W-1:0] prev_q  [MAX_DIM];
    logic [W-1:0] older_q [MAX_DIM];
    logic [W-1:0] nb_prev [MAX_DIM];
    logic [W-1:0] nb_older[MAX_DIM];

    for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
        if (k == MAX_DIM - 1) begin : g_end
            assign nb_prev[k]  = '0;
            assign nb_older[k] = '0;
        end else begin : g_mid
            assign nb_prev[k]  = prev_q[k+1];
            assign nb_older[k] = older_q[k+1];
        end

        dg3_cell #(
            .W(W)
        ) u_cell (
            .aclk      (aclk),
            .shift_en  (shift_en),
            .inject    (inj_pos == IDX_W'(k)),
            .new_prev  (new_sample),
            .new_older (prev_q[0]),
            .nb_prev   (nb_prev[k]),
            .nb_older  (nb_older[k]),
            .prev_q    (prev_q[k]),
            .older_q   (older_q[k])
        );
    end

    assign up   = prev_q[0];
    assign upup = older_q[0];

endmodule

`default_nettype wire

// ----- design/dg3_result_queue.sv -----
// small result queue, two writes and one read per cycle
`default_nettype none

module dg3_result_queue #(
    parameter int ENTRY_W = 30,
    parameter int DEPTH   = dg3_pkg::Q_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire dg3_pkg::push_ctl_t push,
    input  wire logic [ENTRY_W-1:0] entry_a,
    input  wire logic [ENTRY_W-1:0] entry_b,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [ENTRY_W-1:0] out_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ENTRY_W-1:0] mem[DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;
    logic [1:0]         n_push;

    assign pop    = out_valid && out_ready;
    assign n_push = {1'b0, push.first} + {1'b0, push.second};

    always_comb begin
        wptr_next  = PTR_W'(wptr_reg + PTR_W'(n_push));
        rptr_next  = pop ? PTR_W'(rptr_reg + 1'b1) : rptr_reg;
        count_next = CNT_W'(count_reg + CNT_W'(n_push) - CNT_W'(pop));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.first) begin
            mem[wptr_reg] <= entry_a;
            if (push.second) begin
                mem[PTR_W'(wptr_reg + 1'b1)] <= entry_b;
            end
        end else if (push.second) begin
            mem[wptr_reg] <= entry_b;
        end
    end

    assign in_ready  = count_reg <= CNT_W'(DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_entry = mem[rptr_reg];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.first || push.second) |-> in_ready)
        else $error("result queue push without room");

    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && count_reg == CNT_W'(1) && !push.first && !push.second) |=> !out_valid)
        else $error("result queue not empty after last pop");
`endif

endmodule

`default_nettype wire

// ----- design/diagonal_3x3_convolution.sv -----
// diagonal 3x3 convolution with zero padding over a raster-order sample stream
// results: each accepted request pushes its results into the result queue, which holds them until taken
// throughput: one request per cycle while the result queue has room; on the last row each
//   request past column zero gives two results, so the result queue fills and input slows
// reset: position and result queue cleared, dimensions set to 32; line store and delays are not
`default_nettype none

module diagonal_3x3_convolution #(
    parameter int MAX_DIM     = dg3_pkg::MAX_DIM_DEF,
    parameter int SAMPLE_BITS = dg3_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    // pixel_in
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]           s_tdata,
    input  wire logic                                       s_tvalid,
    output logic                                            s_tready,
    // pixel_out, out_row, out_col
    output logic [((SAMPLE_BITS+2+2*$clog2(MAX_DIM)+7)/8)*8-1:0] m_tdata,
    // frame_done
    output logic                                            m_tlast,
    // run_last
    output logic                                            m_tuser,
    output logic                                            m_tvalid,
    input  wire logic                                       m_tready,
    input  wire logic                                       psel,
    input  wire logic                                       penable,
    input  wire logic                                       pwrite,
    input  wire logic [dg3_pkg::APB_AW-1:0]                 paddr,
    input  wire logic [dg3_pkg::APB_DW-1:0]                 pwdata,
    output logic      [dg3_pkg::APB_DW-1:0]                 prdata,
    output logic                                            pready
);

    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int PIX_OUT_W = SAMPLE_BITS + 2;
    localparam int DATA_W    = PIX_OUT_W + 2 * IDX_W;
    localparam int ENTRY_W   = DATA_W + 2;
    localparam int OUT_DW    = ((DATA_W + 7) / 8) * 8;
    localparam int DIM_W     = ($clog2(MAX_DIM + 1) > dg3_pkg::DIM_MIN_BITS) ?
                               $clog2(MAX_DIM + 1) : dg3_pkg::DIM_MIN_BITS;

    function automatic logic [IDX_W-1:0] eff_last(input logic [DIM_W-1:0] raw);
        logic [DIM_W-1:0] dec;
        dec = DIM_W'(raw - 1'b1);
        if (raw == '0) begin
            return '0;
        end else if (raw > DIM_W'(MAX_DIM)) begin
            return IDX_W'(MAX_DIM - 1);
        end else begin
            return dec[IDX_W-1:0];
        end
    endfunction

    // configuration
    logic [DIM_W-1:0] rows_raw_reg;
    logic [DIM_W-1:0] cols_raw_reg;
    logic [IDX_W-1:0] last_row_reg;
    logic [IDX_W-1:0] last_col_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_raw_reg <= DIM_W'(dg3_pkg::DIM_RESET);
            cols_raw_reg <= DIM_W'(dg3_pkg::DIM_RESET);
            last_row_reg <= eff_last(DIM_W'(dg3_pkg::DIM_RESET));
            last_col_reg <= eff_last(DIM_W'(dg3_pkg::DIM_RESET));
        end else if (cfg_wr) begin
            unique case (paddr[2])
                dg3_pkg::REG_ROWS: begin
                    rows_raw_reg <= pwdata[DIM_W-1:0];
                    last_row_reg <= eff_last(pwdata[DIM_W-1:0]);
                end
                dg3_pkg::REG_COLS: begin
                    cols_raw_reg <= pwdata[DIM_W-1:0];
                    last_col_reg <= eff_last(pwdata[DIM_W-1:0]);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            dg3_pkg::REG_ROWS: prdata = dg3_pkg::APB_DW'(rows_raw_reg);
            dg3_pkg::REG_COLS: prdata = dg3_pkg::APB_DW'(cols_raw_reg);
            default:           prdata = '0;
        endcase
    end

    // raster position
    logic             accept;
    logic [IDX_W-1:0] row_pos_reg, row_pos_next;
    logic [IDX_W-1:0] col_pos_reg, col_pos_next;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;

    assign accept = s_tvalid && s_tready;

    always_comb begin
        if (row_pos_reg > last_row_reg || col_pos_reg > last_col_reg) begin
            r = '0;
            c = '0;
        end else begin
            r = row_pos_reg;
            c = col_pos_reg;
        end
        if (c != last_col_reg) begin
            col_pos_next = IDX_W'(c + 1'b1);
            row_pos_next = r;
        end else begin
            col_pos_next = '0;
            row_pos_next = (r != last_row_reg) ? IDX_W'(r + 1'b1) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end else if (cfg_wr) begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end else if (accept) begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

    // line store and diagonal delays
    logic signed [SAMPLE_BITS-1:0] px;
    logic        [SAMPLE_BITS-1:0] up;
    logic        [SAMPLE_BITS-1:0] upup;
    logic signed [SAMPLE_BITS-1:0] up_dly_reg;
    logic        [SAMPLE_BITS-1:0] upup_dly1_reg;
    logic signed [SAMPLE_BITS-1:0] upup_dly2_reg;

    assign px = s_tdata[SAMPLE_BITS-1:0];

    dg3_line_chain #(
        .MAX_DIM (MAX_DIM),
        .W       (SAMPLE_BITS)
    ) u_line (
        .aclk       (aclk),
        .shift_en   (accept),
        .inj_pos    (last_col_reg),
        .new_sample (px),
        .up         (up),
        .upup       (upup)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            up_dly_reg    <= up;
            upup_dly1_reg <= upup;
            upup_dly2_reg <= upup_dly1_reg;
        end
    end

    // results
    logic                        has_diag;
    logic                        has_self;
    logic                        has_upup;
    logic signed [PIX_OUT_W-1:0] px_x;
    logic signed [PIX_OUT_W-1:0] diag_up;
    logic signed [PIX_OUT_W-1:0] diag_upup;
    logic signed [PIX_OUT_W-1:0] sum_diag;
    logic signed [PIX_OUT_W-1:0] sum_self;
    logic        [ENTRY_W-1:0]   entry_a;
    logic        [ENTRY_W-1:0]   entry_b;
    logic                        frame_end;
    dg3_pkg::push_ctl_t          push;

    always_comb begin
        has_diag  = (r != '0) && (c != '0);
        has_upup  = (r > IDX_W'(1)) && (c > IDX_W'(1));
        has_self  = (r == last_row_reg) || (c == last_col_reg);
        frame_end = (r == last_row_reg) && (c == last_col_reg);
        px_x      = PIX_OUT_W'(px);
        diag_up   = has_diag ? PIX_OUT_W'(up_dly_reg) : '0;
        diag_upup = has_upup ? PIX_OUT_W'(upup_dly2_reg) : '0;
        sum_diag  = PIX_OUT_W'(diag_upup + diag_up + px_x);
        sum_self  = PIX_OUT_W'(diag_up + px_x);
        entry_a   = {1'b0, !has_self, IDX_W'(c - 1'b1), IDX_W'(r - 1'b1), sum_diag};
        entry_b   = {frame_end, 1'b1, c, r, sum_self};
        push.first  = accept && has_diag;
        push.second = accept && has_self;
    end

    logic [ENTRY_W-1:0] q_entry;

    dg3_result_queue #(
        .ENTRY_W (ENTRY_W),
        .DEPTH   (dg3_pkg::Q_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .entry_a   (entry_a),
        .entry_b   (entry_b),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_entry (q_entry)
    );

    assign m_tdata = OUT_DW'(q_entry[DATA_W-1:0]);
    assign m_tuser = q_entry[DATA_W];
    assign m_tlast = q_entry[DATA_W+1];

`ifndef SYNTHESIS
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("frame end result not marked last of its request");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_pos_reg <= last_row_reg) && (col_pos_reg <= last_col_reg))
        else $error("raster position outside frame");

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !cfg_wr && frame_end) |=> (row_pos_reg == '0) && (col_pos_reg == '0))
        else $error("position did not wrap at frame end");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/diagonal_3x3_convolution_test.sv -----
// self-checking testbench for the diagonal 3x3 convolution block
`default_nettype none

module diagonal_3x3_convolution_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_SAMPLES = 260;
    localparam int TAIL_SAMPLES = 34;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [17:0] pix;
        logic [4:0]  row;
        logic [4:0]  col;
        logic        run_last;
        logic        frame_done;
    } conv_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [15:0] s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // pixel_out [17:0], out_row [22:18], out_col [27:23]
    logic [31:0] m_tdata;
    // frame_done
    logic        m_tlast;
    // run_last
    logic        m_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [dg3_pkg::APB_AW-1:0] paddr = '0;
    logic [dg3_pkg::APB_DW-1:0] pwdata = '0;
    logic [dg3_pkg::APB_DW-1:0] prdata;
    logic        pready;

    diagonal_3x3_convolution i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state
    logic [5:0] rows_reg = 6'd32;
    logic [5:0] cols_reg = 6'd32;
    int line_above [32];
    int line_two_above [32];
    int cur_row = 0;
    int cur_col = 0;
    int above_dly = 0;
    int two_above_dly1 = 0;
    int two_above_dly2 = 0;

    conv_result_t expected_px [$];
    logic [15:0] pending_px [$];
    int samples_queued = 0;
    int samples_taken = 0;
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    function automatic int eff_dim(input logic [5:0] v);
        if (v == 0) return 1;
        if (v > 32) return 32;
        return int'(v);
    endfunction

    function automatic void convolve_sample(input logic [15:0] raw);
        int rows_eff, cols_eff, r, c, px, up, upup, d_up, d_upup;
        bit diag, self;
        conv_result_t res;
        rows_eff = eff_dim(rows_reg);
        cols_eff = eff_dim(cols_reg);
        r = cur_row;
        c = cur_col;
        px = $signed(raw);
        if (r >= rows_eff || c >= cols_eff) begin
            r = 0;
            c = 0;
        end
        up = line_above[c];
        upup = line_two_above[c];
        d_up = (r >= 1 && c >= 1) ? above_dly : 0;
        d_upup = (r >= 2 && c >= 2) ? two_above_dly2 : 0;
        diag = (r >= 1 && c >= 1);
        self = (r == rows_eff - 1 || c == cols_eff - 1);
        if (diag) begin
            res.pix = 18'(d_upup + d_up + px);
            res.row = 5'(r - 1);
            res.col = 5'(c - 1);
            res.run_last = !self;
            res.frame_done = 1'b0;
            expected_px.push_back(res);
        end
        if (self) begin
            res.pix = 18'(d_up + px);
            res.row = 5'(r);
            res.col = 5'(c);
            res.run_last = 1'b1;
            res.frame_done = (r == rows_eff - 1 && c == cols_eff - 1);
            expected_px.push_back(res);
        end
        line_two_above[c] = up;
        line_above[c] = px;
        two_above_dly2 = two_above_dly1;
        two_above_dly1 = upup;
        above_dly = up;
        if (c + 1 < cols_eff) begin
            cur_col = c + 1;
            cur_row = r;
        end else begin
            cur_col = 0;
            cur_row = (r + 1 < rows_eff) ? r + 1 : 0;
        end
    endfunction

    // sample driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                convolve_sample(s_tdata);
                samples_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_px.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata <= pending_px.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        conv_result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.pix = m_tdata[17:0];
                got.row = m_tdata[22:18];
                got.col = m_tdata[27:23];
                got.run_last = m_tuser;
                got.frame_done = m_tlast;
                if (expected_px.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result: pix=%0d row=%0d col=%0d last=%b done=%b",
                                 $signed(got.pix), got.row, got.col, got.run_last,
                                 got.frame_done);
                end else begin
                    want = expected_px.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"result differs: expected pix=%0d row=%0d col=%0d ",
                                      "last=%b done=%b, got pix=%0d row=%0d col=%0d ",
                                      "last=%b done=%b"},
                                     $signed(want.pix), want.row, want.col, want.run_last,
                                     want.frame_done, $signed(got.pix), got.row, got.col,
                                     got.run_last, got.frame_done);
                    end
                end
            end
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("diagonal_3x3_convolution: mismatch");
                $finish;
            end
        end
    end

    task automatic write_dim(input logic idx, input logic [5:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {26'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == dg3_pkg::REG_ROWS) rows_reg = value;
        else cols_reg = value;
        cur_row = 0;
        cur_col = 0;
    endtask

    task automatic queue_sample(input logic [15:0] v);
        pending_px.push_back(v);
        samples_queued++;
    endtask

    task automatic drain;
        while (samples_taken != samples_queued) @(posedge aclk);
        @(posedge aclk);
        while (expected_px.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(15))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
    endtask

    initial begin
        int phase, n, i;
        logic [5:0] nr, nc;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full-scale positive then negative frames
        write_dim(dg3_pkg::REG_ROWS, 6'd3);
        write_dim(dg3_pkg::REG_COLS, 6'd3);
        for (i = 0; i < 9; i++) queue_sample(16'h7fff);
        for (i = 0; i < 9; i++) queue_sample(16'h8000);
        drain();
        // zero dimensions act as one
        write_dim(dg3_pkg::REG_ROWS, 6'd0);
        write_dim(dg3_pkg::REG_COLS, 6'd0);
        queue_sample(16'h0000);
        queue_sample(16'hffff);
        drain();
        // oversize dimensions clamp
        write_dim(dg3_pkg::REG_ROWS, 6'd63);
        write_dim(dg3_pkg::REG_COLS, 6'd63);
        queue_sample(16'h0001);
        queue_sample(16'h5555);
        queue_sample(16'haaaa);
        drain();

        // long receiver hold-off with the sender running flat out
        write_dim(dg3_pkg::REG_ROWS, 6'd5);
        write_dim(dg3_pkg::REG_COLS, 6'd6);
        set_idling(0);
        hold_req = 150;
        for (i = 0; i < 30; i++) queue_sample(pick_sample());
        drain();

        phase = 0;
        while (samples_queued < RANDOM_SAMPLES - TAIL_SAMPLES) begin
            case ($urandom_range(9))
                0: begin nr = 6'd32; nc = 6'($urandom_range(1, 2)); end
                1: begin nr = 6'($urandom_range(1, 2)); nc = 6'd32; end
                2: begin nr = 6'($urandom_range(0, 63)); nc = 6'($urandom_range(0, 3)); end
                default: begin
                    nr = 6'($urandom_range(1, 6));
                    nc = 6'($urandom_range(1, 6));
                end
            endcase
            n = eff_dim(nr) * eff_dim(nc);
            if (n > 64) n = $urandom_range(20, 40);
            else if ($urandom_range(2) == 0) n = 2 * n + $urandom_range(0, 3);
            else n = n + $urandom_range(0, 2);
            set_idling(phase % 4);
            write_dim(dg3_pkg::REG_ROWS, nr);
            write_dim(dg3_pkg::REG_COLS, nc);
            for (i = 0; i < n; i++) queue_sample(pick_sample());
            drain();
            phase++;
        end

        // back to the reset dimensions for the tail
        set_idling(0);
        write_dim(dg3_pkg::REG_ROWS, 6'd32);
        write_dim(dg3_pkg::REG_COLS, 6'd32);
        for (i = 0; i < TAIL_SAMPLES; i++) queue_sample(pick_sample());
        drain();

        if (mismatches == 0) begin
            $display("diagonal_3x3_convolution: match");
        end else begin
            $display("diagonal_3x3_convolution: mismatch");
        end
        $finish;
    end
endmodule

`default_nettype wire
